### design/nhfe_pkg.sv
package nhfe_pkg;

    localparam logic [7:0] PREAMBLE_BYTE    = 8'h00;
    localparam logic [7:0] START_BYTE       = 8'hFF;
    localparam logic [7:0] DIR_HOST_TO_CTRL = 8'hD4;
    localparam logic [7:0] MAX_PAYLOAD      = 8'd254;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // position of each byte within one serialized record
    localparam logic [2:0] IDX_PRE0  = 3'd0;
    localparam logic [2:0] IDX_PRE1  = 3'd1;
    localparam logic [2:0] IDX_START = 3'd2;
    localparam logic [2:0] IDX_LEN   = 3'd3;
    localparam logic [2:0] IDX_LCS   = 3'd4;
    localparam logic [2:0] IDX_DIR   = 3'd5;
    localparam logic [2:0] IDX_DATA  = 3'd6;
    localparam logic [2:0] IDX_DCS   = 3'd7;

    typedef struct packed {
        logic       first;
        logic [7:0] data;
        logic [7:0] len;
        logic       has_dcs;
        logic [7:0] dcs;
    } t_cmd;

endpackage

### design/nhfe_front.sv
module nhfe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_q_full,
    input  logic [7:0]    i_data_byte,
    input  logic [7:0]    i_frame_length,
    output logic          o_q_wr,
    output nhfe_pkg::t_cmd o_cmd
);
    import nhfe_pkg::*;

    logic [7:0] r_remain;
    logic [7:0] r_sum;
    logic [7:0] n_remain;
    logic [7:0] n_sum;
    logic [7:0] len_c;
    logic [7:0] sum_base;
    logic       first;

    always_comb begin
        first = (r_remain == 8'd0);
        if (i_frame_length == 8'd0) begin
            len_c = 8'd1;
        end else if (i_frame_length > MAX_PAYLOAD) begin
            len_c = MAX_PAYLOAD;
        end else begin
            len_c = i_frame_length;
        end
        sum_base = first ? DIR_HOST_TO_CTRL : r_sum;
        n_sum    = sum_base + i_data_byte;
        n_remain = first ? (len_c - 8'd1) : (r_remain - 8'd1);

        o_cmd.first   = first;
        o_cmd.data    = i_data_byte;
        o_cmd.len     = len_c;
        o_cmd.has_dcs = (n_remain == 8'd0);
        o_cmd.dcs     = 8'd0 - n_sum;
    end

    assign o_q_wr = i_push && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain <= 8'd0;
            r_sum    <= 8'd0;
        end else if (o_q_wr) begin
            r_remain <= n_remain;
            r_sum    <= o_cmd.has_dcs ? 8'd0 : n_sum;
        end
    end

endmodule

### design/nhfe_cmd_fifo.sv
module nhfe_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  nhfe_pkg::t_cmd i_cmd,
    input  logic           i_rd,
    output logic           o_full,
    output logic           o_valid,
    output nhfe_pkg::t_cmd o_cmd
);
    import nhfe_pkg::*;

    t_cmd                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_cnt;
    logic                wr_ok;
    logic                rd_ok;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (rd_ok) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({wr_ok, rd_ok})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### design/nhfe_back.sv
module nhfe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  nhfe_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_out_byte,
    output logic           o_end_of_run,
    output logic           o_end_of_frame
);
    import nhfe_pkg::*;

    logic       r_mid;
    logic [2:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_end_of_run;
    logic       r_end_of_frame;

    logic       load;
    logic       emit;
    logic [2:0] e;
    logic [2:0] last;
    logic [7:0] n_byte;

    always_comb begin
        e    = r_mid ? r_idx : (i_cmd.first ? IDX_PRE0 : IDX_DATA);
        last = i_cmd.has_dcs ? IDX_DCS : IDX_DATA;
        unique case (e)
            IDX_PRE0:  n_byte = PREAMBLE_BYTE;
            IDX_PRE1:  n_byte = PREAMBLE_BYTE;
            IDX_START: n_byte = START_BYTE;
            IDX_LEN:   n_byte = i_cmd.len + 8'd1;
            IDX_LCS:   n_byte = START_BYTE - i_cmd.len;
            IDX_DIR:   n_byte = DIR_HOST_TO_CTRL;
            IDX_DATA:  n_byte = i_cmd.data;
            IDX_DCS:   n_byte = i_cmd.dcs;
        endcase
    end

    assign load      = !r_out_valid || i_pop;
    assign emit      = load && i_cmd_valid;
    assign o_cmd_pop = emit && (e == last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_idx       <= IDX_PRE0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= emit;
            end
            if (emit) begin
                if (e == last) begin
                    r_mid <= 1'b0;
                    r_idx <= IDX_PRE0;
                end else begin
                    r_mid <= 1'b1;
                    r_idx <= e + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte     <= n_byte;
            r_end_of_run   <= (e == last);
            r_end_of_frame <= (e == IDX_DCS);
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_end_of_run   = r_end_of_run;
    assign o_end_of_frame = r_end_of_frame;

`ifndef SYNTHESIS
    a_mid_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> i_cmd_valid)
        else $error("record in progress without queued entry");

    a_mid_not_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> (r_idx != IDX_PRE0))
        else $error("mid-record index back at start");

    a_dcs_only_when_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (e == IDX_DCS)) |-> i_cmd.has_dcs)
        else $error("checksum emitted for record without one");
`endif

endmodule

### design/nfc_host_frame_encoder.sv
// Host-to-controller frame encoder: each pushed payload byte yields a run of output
// bytes. The first byte of a frame (command code, with its length, clamped to 1..254)
// yields 00 00 FF, LEN, LCS, D4 and the byte; later bytes pass through; the last byte
// is followed by the DCS checksum (end_of_frame set). end_of_run marks the last byte of
// each run. The output serializer sends one byte per cycle unless stalled by an empty
// queue or an unpopped output; a later payload byte yields 1 output byte (2 with DCS)
// and a first byte 7 (8 with DCS). A 4-entry queue between input classification and
// serializer lets input run ahead; full rises only once it fills. A pushed byte is
// written into the queue and then into the output byte register before it shows.
module nfc_host_frame_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_frame_length,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_run,
    output logic       o_end_of_frame
);
    import nhfe_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_wr;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign full = q_full;

    nhfe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_q_full       (q_full),
        .i_data_byte    (i_data_byte),
        .i_frame_length (i_frame_length),
        .o_q_wr         (q_wr),
        .o_cmd          (front_cmd)
    );

    nhfe_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (front_cmd),
        .i_rd    (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    nhfe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .i_cmd          (head_cmd),
        .o_cmd_pop      (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_end_of_run   (o_end_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
